### rtl/mpcirc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle generator package
// Widths, codes and the job record passed from the stepping front end to the
// point emitter.
// ----------------------------------------------------------------------------
package mpcirc_pkg;

   localparam int COORD_BITS     = 16;
   localparam int POINT_BITS     = COORD_BITS + 1;
   localparam int OFF_BITS       = 14;
   localparam int DEC_BITS       = 18;
   localparam int STATUS_BITS    = 2;
   localparam int REQ_TDATA_BITS = ((2 * COORD_BITS + OFF_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((2 * POINT_BITS + 7) / 8) * 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int POINTS_PER_POS = 8;
   localparam int BEAT_BITS      = $clog2(POINTS_PER_POS);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [POINT_BITS-1:0] point_type;
   typedef logic [OFF_BITS-1:0]          offset_type;
   typedef logic [DEC_BITS-1:0]          decision_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_POINT = 2'd0,
      STATUS_DONE  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic       plot;
      status_type status;
      coord_type  cx;
      coord_type  cy;
      offset_type ox;
      offset_type oy;
   } job_type;

endpackage
`default_nettype wire

### rtl/mpcirc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle front end
// Accepts start and step beats, keeps the circle state and the decision term,
// and queues one job per accepted beat: a point group or a status result.
// ----------------------------------------------------------------------------
module mpcirc_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [mpcirc_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  wire logic [0:0]                           req_tuser,
   input  wire logic                                 queue_full,
   output logic                                      push_valid,
   output mpcirc_pkg::job_type                       push_job
);
   import mpcirc_pkg::*;

   offset_type   ox_ff, ox_in, oy_ff, oy_in;
   decision_type dec_ff, dec_in;
   coord_type    cx_ff, cx_in, cy_ff, cy_in;
   logic         active_ff, active_in;

   coord_type    req_cx, req_cy;
   offset_type   req_radius;
   decision_type x_ext, y_ext, r_ext;
   offset_type   next_x, next_y;
   decision_type next_dec;
   logic         accept;

   assign req_cx     = req_tdata[0 +: COORD_BITS];
   assign req_cy     = req_tdata[COORD_BITS +: COORD_BITS];
   assign req_radius = req_tdata[2 * COORD_BITS +: OFF_BITS];
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   assign x_ext = {{(DEC_BITS - OFF_BITS){1'b0}}, ox_ff};
   assign y_ext = {{(DEC_BITS - OFF_BITS){1'b0}}, oy_ff};
   assign r_ext = {{(DEC_BITS - OFF_BITS){1'b0}}, req_radius};

   always_comb begin
      next_x = ox_ff + OFF_BITS'(1);
      if (dec_ff[DEC_BITS-1] || (dec_ff == '0)) begin
         next_dec = dec_ff + (x_ext << 2) + DEC_BITS'(6);
         next_y   = oy_ff;
      end else begin
         next_dec = dec_ff + ((x_ext - y_ext) << 2) + DEC_BITS'(10);
         next_y   = oy_ff - OFF_BITS'(1);
      end
   end

   always_comb begin
      ox_in           = ox_ff;
      oy_in           = oy_ff;
      dec_in          = dec_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      active_in       = active_ff;
      push_valid      = accept;
      push_job.plot   = 1'b0;
      push_job.status = STATUS_DONE;
      push_job.cx     = cx_ff;
      push_job.cy     = cy_ff;
      push_job.ox     = ox_ff;
      push_job.oy     = oy_ff;
      if (accept) begin
         if (kind_type'(req_tuser[0]) == KIND_START) begin
            if (req_radius == '0) begin
               active_in       = 1'b0;
               push_job.status = STATUS_ERROR;
            end else begin
               cx_in           = req_cx;
               cy_in           = req_cy;
               ox_in           = '0;
               oy_in           = req_radius;
               dec_in          = DEC_BITS'(3) - (r_ext << 1);
               active_in       = 1'b1;
               push_job.plot   = 1'b1;
               push_job.status = STATUS_POINT;
               push_job.cx     = req_cx;
               push_job.cy     = req_cy;
               push_job.ox     = '0;
               push_job.oy     = req_radius;
            end
         end else if (active_ff) begin
            ox_in  = next_x;
            oy_in  = next_y;
            dec_in = next_dec;
            push_job.ox = next_x;
            push_job.oy = next_y;
            if (next_x > next_y) begin
               active_in = 1'b0;
            end else begin
               push_job.plot   = 1'b1;
               push_job.status = STATUS_POINT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff     <= '0;
         oy_ff     <= '0;
         dec_ff    <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         active_ff <= 1'b0;
      end else begin
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         dec_ff    <= dec_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         active_ff <= active_in;
      end
   end

endmodule
`default_nettype wire

### rtl/mpcirc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle job queue
// Short first-in first-out queue of jobs between the front end and the
// point emitter.
// ----------------------------------------------------------------------------
module mpcirc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire mpcirc_pkg::job_type push_job,
   output logic                     queue_full,
   input  wire logic                pop,
   output logic                     head_valid,
   output mpcirc_pkg::job_type      head_job
);
   import mpcirc_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign queue_full = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/mpcirc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle point emitter
// Turns the job at the head of the queue into result beats: eight symmetric
// points for a point group, or one status beat, through an output register.
// ----------------------------------------------------------------------------
module mpcirc_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  head_valid,
   input  wire mpcirc_pkg::job_type                   head_job,
   output logic                                       pop,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [mpcirc_pkg::RSP_TDATA_BITS-1:0]      rsp_tdata,
   output logic [mpcirc_pkg::STATUS_BITS-1:0]         rsp_tuser,
   output logic                                       rsp_tlast
);
   import mpcirc_pkg::*;

   logic                 valid_ff, valid_in;
   logic [BEAT_BITS-1:0] beat_ff, beat_in;
   point_type            px_ff, px_in, py_ff, py_in;
   status_type           status_ff, status_in;
   logic                 last_ff, last_in;

   logic                 advance;
   logic                 last_beat;
   offset_type           off_a, off_b;
   point_type            cx_ext, cy_ext, a_ext, b_ext, calc_x, calc_y;

   assign advance   = head_valid && (!valid_ff || rsp_tready);
   assign last_beat = (beat_ff == BEAT_BITS'(POINTS_PER_POS - 1));

   assign off_a  = beat_ff[2] ? head_job.oy : head_job.ox;
   assign off_b  = beat_ff[2] ? head_job.ox : head_job.oy;
   assign cx_ext = {head_job.cx[COORD_BITS-1], head_job.cx};
   assign cy_ext = {head_job.cy[COORD_BITS-1], head_job.cy};
   assign a_ext  = {{(POINT_BITS - OFF_BITS){1'b0}}, off_a};
   assign b_ext  = {{(POINT_BITS - OFF_BITS){1'b0}}, off_b};
   assign calc_x = beat_ff[0] ? (cx_ext - a_ext) : (cx_ext + a_ext);
   assign calc_y = beat_ff[1] ? (cy_ext - b_ext) : (cy_ext + b_ext);

   always_comb begin
      valid_in  = valid_ff;
      beat_in   = beat_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      status_in = status_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in  = 1'b1;
         status_in = head_job.status;
         if (head_job.plot) begin
            px_in   = calc_x;
            py_in   = calc_y;
            last_in = last_beat;
            beat_in = beat_ff + 1'b1;
            pop     = last_beat;
         end else begin
            px_in   = '0;
            py_in   = '0;
            last_in = 1'b1;
            beat_in = '0;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - 2 * POINT_BITS){1'b0}}, py_ff, px_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

### rtl/midpoint_circle_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint circle generator unit
// Rasterizes circle octants with the midpoint decision rule, one position per
// step beat, and emits the eight symmetric points of each position.
// ----------------------------------------------------------------------------
// A start beat loads center and radius and returns the eight points of the
// first position; each step beat advances one position and returns its eight
// points, one beat per cycle while rsp_tready is high, with tlast on the
// eighth. A step past the end of the octant or with no circle running returns
// one finished status beat, and a start with radius zero returns one error
// status beat. The front end updates the circle state in the cycle it takes a
// beat and hands a job to a two-entry queue, so it keeps taking beats while
// points are still going out; the point emitter sends one point per cycle
// while rsp_tready is high.
module midpoint_circle_generator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // center_x [15:0], center_y [31:16], radius [45:32], zero padding above
   input  wire logic [mpcirc_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // kind [0]: start or step
   input  wire logic [0:0]                           req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // point_x [16:0], point_y [33:17], zero padding above
   output logic [mpcirc_pkg::RSP_TDATA_BITS-1:0]     rsp_tdata,
   // status [1:0]
   output logic [mpcirc_pkg::STATUS_BITS-1:0]        rsp_tuser,
   output logic                                      rsp_tlast
);
   import mpcirc_pkg::*;

   logic    queue_full;
   logic    push_valid;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   mpcirc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   mpcirc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .queue_full (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mpcirc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

### test/midpoint_circle_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// Midpoint circle generator unit testbench
// Feeds start and step beats into the generator and checks every result beat
// against a cycle-free model of the octant walk kept inside this bench. A
// short table covers reset, radius extremes, error and idle cases, then
// random circles with random centers follow, under random stalls on both
// sides and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module midpoint_circle_generator_unit_tb;
   import mpcirc_pkg::*;

   typedef struct packed {
      point_type  px;
      point_type  py;
      status_type st;
      logic       last;
   } plot_beat_type;

   typedef struct packed {
      kind_type   kind;
      coord_type  cx;
      coord_type  cy;
      offset_type r;
      logic       typed;
      status_type st;
   } stim_row_type;

   localparam int RAND_ITEMS = 356;
   localparam int CALM_ITEMS = 50;
   localparam int HOLD_AT    = 800;
   localparam int HOLD_LEN   = 300;
   localparam int DRAIN      = 50;
   localparam int MAX_SHOWN  = 10;
   localparam int MAX_STEPS  = 40;
   localparam int PAD_BITS   = REQ_TDATA_BITS - 2 * COORD_BITS - OFF_BITS;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic [0:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]    rsp_tuser;
   logic                      rsp_tlast;

   logic       row_typed;
   status_type row_status;
   bit         calm;

   offset_type                  walk_x;
   offset_type                  walk_y;
   logic signed [DEC_BITS-1:0]  walk_dec;
   coord_type                   walk_cx;
   coord_type                   walk_cy;
   bit                          circ_on;

   plot_beat_type points_due[$];
   plot_beat_type fresh_points[$];
   stim_row_type  stim_tab[$];
   int            bad_beats;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   midpoint_circle_generator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   task put_point(input int px, input int py, input status_type st, input logic last);
      plot_beat_type b;
      b.px   = px[POINT_BITS-1:0];
      b.py   = py[POINT_BITS-1:0];
      b.st   = st;
      b.last = last;
      fresh_points.push_back(b);
   endtask

   task put_octants;
      int h, k, x, y;
      h = int'(walk_cx);
      k = int'(walk_cy);
      x = int'(walk_x);
      y = int'(walk_y);
      put_point(h + x, k + y, STATUS_POINT, 1'b0);
      put_point(h - x, k + y, STATUS_POINT, 1'b0);
      put_point(h + x, k - y, STATUS_POINT, 1'b0);
      put_point(h - x, k - y, STATUS_POINT, 1'b0);
      put_point(h + y, k + x, STATUS_POINT, 1'b0);
      put_point(h - y, k + x, STATUS_POINT, 1'b0);
      put_point(h + y, k - x, STATUS_POINT, 1'b0);
      put_point(h - y, k - x, STATUS_POINT, 1'b1);
   endtask

   task trace_circle(input kind_type kind, input coord_type cx, input coord_type cy,
                     input offset_type r);
      int x, y, d;
      fresh_points.delete();
      if (kind == KIND_START) begin
         if (r == 0) begin
            circ_on = 1'b0;
            put_point(0, 0, STATUS_ERROR, 1'b1);
         end else begin
            walk_cx  = cx;
            walk_cy  = cy;
            walk_x   = '0;
            walk_y   = r;
            d        = 3 - 2 * int'(r);
            walk_dec = d[DEC_BITS-1:0];
            circ_on  = 1'b1;
            put_octants();
         end
      end else if (!circ_on) begin
         put_point(0, 0, STATUS_DONE, 1'b1);
      end else begin
         x = int'(walk_x);
         y = int'(walk_y);
         d = int'(walk_dec);
         if (d <= 0) begin
            d = d + 4 * x + 6;
         end else begin
            d = d + 4 * (x - y) + 10;
            y = y - 1;
         end
         x        = x + 1;
         walk_dec = d[DEC_BITS-1:0];
         walk_x   = x[OFF_BITS-1:0];
         walk_y   = y[OFF_BITS-1:0];
         if (walk_x > walk_y) begin
            circ_on = 1'b0;
            put_point(0, 0, STATUS_DONE, 1'b1);
         end else begin
            put_octants();
         end
      end
   endtask

   always @(posedge clock) begin
      plot_beat_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            trace_circle(kind_type'(req_tuser[0]), req_tdata[COORD_BITS-1:0],
                         req_tdata[2*COORD_BITS-1:COORD_BITS],
                         req_tdata[2*COORD_BITS+OFF_BITS-1:2*COORD_BITS]);
            if (row_typed) begin
               want.px   = '0;
               want.py   = '0;
               want.st   = row_status;
               want.last = 1'b1;
               points_due.push_back(want);
            end else begin
               foreach (fresh_points[i]) points_due.push_back(fresh_points[i]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.px   = rsp_tdata[POINT_BITS-1:0];
            got.py   = rsp_tdata[2*POINT_BITS-1:POINT_BITS];
            got.st   = status_type'(rsp_tuser);
            got.last = rsp_tlast;
            if (points_due.size() == 0) begin
               bad_beats++;
               if (bad_beats <= MAX_SHOWN)
                  $display("unexpected beat: x %0d y %0d status %0d last %0b",
                           got.px, got.py, got.st, got.last);
            end else begin
               want = points_due.pop_front();
               if (got !== want) begin
                  bad_beats++;
                  if (bad_beats <= MAX_SHOWN)
                     $display({"beat mismatch: expected x %0d y %0d status %0d last %0b,",
                               " got x %0d y %0d status %0d last %0b"},
                              want.px, want.py, want.st, want.last,
                              got.px, got.py, got.st, got.last);
               end
            end
         end
      end
   end

   task add_row(input kind_type kind, input int cx, input int cy, input int r,
                input logic typed, input status_type st);
      stim_row_type row;
      row.kind  = kind;
      row.cx    = cx[COORD_BITS-1:0];
      row.cy    = cy[COORD_BITS-1:0];
      row.r     = r[OFF_BITS-1:0];
      row.typed = typed;
      row.st    = st;
      stim_tab.push_back(row);
   endtask

   task send_item(input kind_type kind, input coord_type cx, input coord_type cy,
                  input offset_type r, input logic typed, input status_type st);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {{PAD_BITS{1'b0}}, r, cy, cx};
      row_typed  = typed;
      row_status = st;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int sent, steps, pick;
      coord_type cx, cy;
      offset_type r;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      row_typed  = 1'b0;
      row_status = STATUS_POINT;
      calm       = 1'b0;
      bad_beats  = 0;
      circ_on    = 1'b0;
      walk_x     = '0;
      walk_y     = '0;
      walk_dec   = '0;
      walk_cx    = '0;
      walk_cy    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(KIND_STEP,       0,      0,     0, 1'b1, STATUS_DONE);
      add_row(KIND_START,      0,      0,     0, 1'b1, STATUS_ERROR);
      add_row(KIND_START,      0,      0,     1, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,      -1,     -1, 16383, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b1, STATUS_DONE);
      add_row(KIND_START,  32767,  32767, 16383, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_START, -32768, -32768, 16383, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,      -1,     -1, 16383, 1'b0, STATUS_POINT);
      add_row(KIND_START,     -1,     -1,     0, 1'b1, STATUS_ERROR);
      add_row(KIND_STEP,       0,      0,     0, 1'b1, STATUS_DONE);
      add_row(KIND_START,     -1,      1,     3, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b1, STATUS_DONE);
      add_row(KIND_START,  32767, -32768,     5, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b0, STATUS_POINT);
      add_row(KIND_STEP,       0,      0,     0, 1'b1, STATUS_DONE);
      add_row(KIND_START,      0,      0, 16383, 1'b0, STATUS_POINT);

      foreach (stim_tab[i])
         send_item(stim_tab[i].kind, stim_tab[i].cx, stim_tab[i].cy, stim_tab[i].r,
                   stim_tab[i].typed, stim_tab[i].st);

      sent = 0;
      while (sent < RAND_ITEMS) begin
         calm = (sent >= RAND_ITEMS - CALM_ITEMS);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            cx = coord_type'($urandom);
            cy = coord_type'($urandom);
            case ($urandom_range(0, 9))
               0:       r = offset_type'($urandom);
               1:       r = offset_type'(16383);
               default: r = offset_type'($urandom_range(1, 24));
            endcase
            send_item(KIND_START, cx, cy, r, 1'b0, STATUS_POINT);
            sent++;
            steps = 0;
            while (circ_on && steps < MAX_STEPS && $urandom_range(0, 29) != 0) begin
               send_item(KIND_STEP, coord_type'($urandom), coord_type'($urandom),
                         offset_type'($urandom), 1'b0, STATUS_POINT);
               sent++;
               steps++;
            end
            if ($urandom_range(0, 2) == 0) begin
               send_item(KIND_STEP, coord_type'($urandom), coord_type'($urandom),
                         offset_type'($urandom), 1'b0, STATUS_POINT);
               sent++;
            end
         end else if (pick == 7) begin
            send_item(KIND_START, coord_type'($urandom), coord_type'($urandom),
                      '0, 1'b0, STATUS_POINT);
            sent++;
         end else begin
            send_item(KIND_STEP, coord_type'($urandom), coord_type'($urandom),
                      offset_type'($urandom), 1'b0, STATUS_POINT);
            sent++;
         end
      end
      req_tvalid = 1'b0;

      while (points_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (bad_beats == 0 && points_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      int cyc, n;
      bit held;
      rsp_tready = 1'b0;
      cyc  = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (!held && cyc >= HOLD_AT) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_LEN - 1) @(negedge clock);
            cyc += HOLD_LEN - 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            n = $urandom_range(0, 3);
            repeat (n) @(negedge clock);
            cyc += n;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
